FILE: rtl/bps_pkg.sv
// Shared types, codes and helper function of the byte pattern search block.
package bps_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_BUFFER = 1'b1;

  localparam logic [1:0] REG_CASE_SENS   = 2'd0;
  localparam logic [1:0] REG_DIRECTION   = 2'd1;
  localparam logic [1:0] REG_PATTERN_LEN = 2'd2;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CASE_OFFSET  = CHAR_LOWER_A - CHAR_UPPER_A;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef struct packed {
    logic       is_buffer;
    logic [7:0] data_byte;
    logic [5:0] pattern_index;
    logic       last_byte;
  } bps_item_t;

  typedef struct packed {
    logic       exact_cmp;
    logic       direction;
    logic [6:0] pattern_length;
  } bps_cfg_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cs);
    logic [7:0] r;
    r = b;
    if (!cs && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

FILE: rtl/byte_pattern_search.sv
// Path: a last buffer byte's result passes the input register, the queue and stage two
// into the output register. Throughput: one input transaction per cycle while the output
// accepts, set by comparing all PATTERN_MAX window lanes with the aligned pattern store.
// Reset: registers return to exact compare on, forward direction, pattern length 0;
// counters, match flags and queue clear at once; window and pattern store hold no reset value.
// Top level: configuration registers, input stage, queue and search engine.
module byte_pattern_search #(
  parameter int PATTERN_MAX   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // byte_value[7:0], pattern_index[13:8], zero[15:14]
  input  logic        s_axis_tuser,   // operation[0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // match_position[31:0]
  output logic        m_axis_tuser,   // found[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               cs_q, dir_q;
  logic [6:0]         plen_q;
  logic               reg_we;
  bps_pkg::bps_cfg_t  cfg;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  bps_pkg::bps_item_t push_item, pop_item;

  assign pready = 1'b1;
  assign reg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q   <= 1'b1;
      dir_q  <= 1'b0;
      plen_q <= '0;
    end else if (reg_we) begin
      case (paddr[3:2])
        bps_pkg::REG_CASE_SENS:   cs_q   <= pwdata[0];
        bps_pkg::REG_DIRECTION:   dir_q  <= pwdata[0];
        bps_pkg::REG_PATTERN_LEN: plen_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bps_pkg::REG_CASE_SENS:   prdata = {31'd0, cs_q};
      bps_pkg::REG_DIRECTION:   prdata = {31'd0, dir_q};
      bps_pkg::REG_PATTERN_LEN: prdata = {25'd0, plen_q};
      default:                  prdata = '0;
    endcase
  end

  assign cfg.exact_cmp      = cs_q;
  assign cfg.direction      = dir_q;
  assign cfg.pattern_length = plen_q;

  bps_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .push_valid_o  (push_valid),
    .push_item_o   (push_item),
    .push_ready_i  (push_ready)
  );

  bps_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  bps_back #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .cfg_i        (cfg),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_found_o  (m_axis_tuser),
    .out_pos_o    (m_axis_tdata)
  );

endmodule

FILE: rtl/bps_front.sv
// Input stage: accept stream transactions, classify them and hand them to the queue.
module bps_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               s_axis_tlast,
  output logic               push_valid_o,
  output bps_pkg::bps_item_t push_item_o,
  input  logic               push_ready_i
);

  logic               valid_q, valid_d;
  bps_pkg::bps_item_t item_q;
  logic               take;

  assign push_valid_o  = valid_q;
  assign push_item_o   = item_q;
  assign s_axis_tready = !valid_q || push_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.is_buffer     <= (s_axis_tuser == bps_pkg::OP_BUFFER);
      item_q.data_byte     <= s_axis_tdata[7:0];
      item_q.pattern_index <= s_axis_tdata[13:8];
      item_q.last_byte     <= s_axis_tlast && (s_axis_tuser == bps_pkg::OP_BUFFER);
    end
  end

endmodule

FILE: rtl/bps_fifo.sv
// Short queue between the input stage and the search engine.
module bps_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  bps_pkg::bps_item_t push_item_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output bps_pkg::bps_item_t pop_item_o,
  input  logic               pop_ready_i
);

  bps_pkg::bps_item_t                   mem_q [bps_pkg::QUEUE_DEPTH];
  logic [bps_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [bps_pkg::QUEUE_CNT_W-1:0]      count_q, count_d;
  logic                                 push, pop;

  assign push_ready_o = (count_q != bps_pkg::QUEUE_CNT_W'(bps_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/bps_back.sv
// Search engine: pattern store, byte window, parallel compare and result tracking.
module bps_back #(
  parameter int PATTERN_MAX   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  bps_pkg::bps_item_t item_i,
  output logic               item_ready_o,
  input  bps_pkg::bps_cfg_t  cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_found_o,
  output logic [31:0]        out_pos_o
);

  localparam int LEN_W    = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int PAT_BITS = 8 * PATTERN_MAX;

  logic [7:0]               pat_q [PATTERN_MAX];
  logic [7:0]               win_q [PATTERN_MAX];
  logic [7:0]               win_d [PATTERN_MAX];
  logic [POSITION_BITS-1:0] seen_q, seen_inc;
  logic [LEN_W-1:0]         used_len, shift_len;
  logic [LEN_W+2:0]         shift_bits;
  logic [PAT_BITS-1:0]      rev_flat, align_flat;
  logic [PATTERN_MAX-1:0]   lane_ok;
  logic                     active, hit, s1_go, s1_buf, s2_go, pat_we;

  logic                     s2_valid_q, s2_valid_d;
  logic                     s2_last_q, s2_hit_q, s2_empty_q, s2_dir_q;
  logic [POSITION_BITS-1:0] s2_start_q, s2_seen_q;

  logic                     match_seen_q, ms_eff;
  logic [POSITION_BITS-1:0] rep_q, rep_eff, res_pos;
  logic [POSITION_BITS+31:0] res_pos_ext;
  logic                     res_found;

  logic                     out_valid_q, out_valid_d, out_found_q;
  logic [31:0]              out_pos_q;

  // Stage one: classify, update store and window, compare.
  always_comb begin
    if (int'(cfg_i.pattern_length) > PATTERN_MAX) begin
      used_len = LEN_W'(PATTERN_MAX);
    end else begin
      used_len = LEN_W'(cfg_i.pattern_length);
    end
  end

  assign shift_len  = LEN_W'(PATTERN_MAX) - used_len;
  assign shift_bits = {shift_len, 3'b000};

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      rev_flat[8*k +: 8] = pat_q[PATTERN_MAX-1-k];
    end
  end

  assign align_flat = rev_flat >> shift_bits;

  always_comb begin
    win_d[0] = item_i.data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      lane_ok[k] = (LEN_W'(k) >= used_len) ||
                   (bps_pkg::fold_byte(win_d[k], cfg_i.exact_cmp) ==
                    bps_pkg::fold_byte(align_flat[8*k +: 8], cfg_i.exact_cmp));
    end
  end

  assign active   = ~&seen_q;
  assign seen_inc = seen_q + POSITION_BITS'(1);
  assign hit      = active && (used_len != '0) &&
                    (seen_inc >= POSITION_BITS'(used_len)) && (&lane_ok);

  assign s2_go        = s2_valid_q && (!s2_last_q || !out_valid_q || out_ready_i);
  assign item_ready_o = !s2_valid_q || s2_go;
  assign s1_go        = item_valid_i && item_ready_o;
  assign s1_buf       = s1_go && item_i.is_buffer;
  assign pat_we       = s1_go && !item_i.is_buffer &&
                        (int'(item_i.pattern_index) < PATTERN_MAX);

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_q[IDX_W'(item_i.pattern_index)] <= item_i.data_byte;
    end
    if (s1_buf && active) begin
      win_q <= win_d;
    end
    if (s1_buf) begin
      s2_last_q  <= item_i.last_byte;
      s2_hit_q   <= hit;
      s2_empty_q <= (used_len == '0);
      s2_dir_q   <= cfg_i.direction;
      s2_start_q <= seen_inc - POSITION_BITS'(used_len);
      s2_seen_q  <= active ? seen_inc : seen_q;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s1_buf) begin
      s2_valid_d = 1'b1;
    end else if (s2_go) begin
      s2_valid_d = 1'b0;
    end
  end

  // Stage two: track first or last match start and form the result.
  assign ms_eff  = match_seen_q || s2_hit_q;
  assign rep_eff = (s2_hit_q && (s2_dir_q || !match_seen_q)) ? s2_start_q : rep_q;

  always_comb begin
    res_found = s2_empty_q || ms_eff;
    if (s2_empty_q) begin
      res_pos = s2_dir_q ? s2_seen_q : '0;
    end else if (ms_eff) begin
      res_pos = rep_eff;
    end else begin
      res_pos = '0;
    end
  end

  assign res_pos_ext = {32'd0, res_pos};

  always_comb begin
    out_valid_d = out_valid_q;
    if (s2_go && s2_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= '0;
      s2_valid_q   <= 1'b0;
      match_seen_q <= 1'b0;
      rep_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_buf) begin
        if (item_i.last_byte) begin
          seen_q <= '0;
        end else if (active) begin
          seen_q <= seen_inc;
        end
      end
      if (s2_go) begin
        if (s2_last_q) begin
          match_seen_q <= 1'b0;
          rep_q        <= '0;
        end else begin
          match_seen_q <= ms_eff;
          rep_q        <= rep_eff;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s2_last_q) begin
      out_found_q <= res_found;
      out_pos_q   <= res_pos_ext[31:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_pos_o   = out_pos_q;

endmodule
